FILE: src/ispv_pkg.sv
// ispv_pkg: constants and fixed-point helpers for the icon pixel variant unit
// register indexes, format bits, constant dividers and byte packing
// no dependencies
package ispv_pkg;

    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VARIANT_MASK = 2'd1;

    localparam logic [1:0] FMT_RESET = 2'd2;
    localparam logic [2:0] MASK_RESET = 3'd0;

    // format bit meanings
    localparam int unsigned FMT_BIG_BIT = 0;
    localparam int unsigned FMT_ALPHA_BIT = 1;

    // variant mask bit meanings
    localparam int unsigned MASK_DIS_BIT = 0;
    localparam int unsigned MASK_ACT_BIT = 1;
    localparam int unsigned MASK_PART_BIT = 2;

    localparam logic [7:0] OPAQUE_ALPHA = 8'd255;
    localparam logic [10:0] DIS_OFFSET = 11'd648;
    localparam logic [10:0] DIS_CLK_OFFSET = 11'd564;

    typedef logic [7:0] chan_t;
    typedef chan_t pix4_t [4];

    // floor(x/5) for x < 1280 via reciprocal 13108 / 2^16
    function automatic chan_t div5_f(input logic [10:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd13108;
        return p[23:16];
    endfunction

    // floor(x/10) for x < 2560 via reciprocal 6554 / 2^16
    function automatic chan_t div10_f(input logic [11:0] x);
        logic [24:0] p;
        p = 25'(x) * 25'd6554;
        return p[23:16];
    endfunction

    // floor(x/100) for x < 25600 via reciprocal 10486 / 2^20
    function automatic chan_t div100_f(input logic [14:0] x);
        logic [28:0] p;
        p = 29'(x) * 29'd10486;
        return p[27:20];
    endfunction

    // logical channel k lands at byte k, or byte 3-k when big-endian
    function automatic logic [31:0] pack_f(input logic big, input pix4_t v);
        logic [31:0] r;
        if (big)
        begin
            r = {v[0], v[1], v[2], v[3]};
        end
        else
        begin
            r = {v[3], v[2], v[1], v[0]};
        end
        return r;
    endfunction

endpackage

FILE: src/icon_state_pixel_variants_unit.sv
// icon_state_pixel_variants_unit: five-stage pipeline building four pixel variants
// depends on ispv_pkg
//
// sustains one item per cycle while out_ready is high
// five register stages, each holding one item with its valid bit
// stalls back up stage by stage; a full stage holds until the next one frees
// reset clears all valid bits and returns pixel_format to 2 and variant_mask to 0
module icon_state_pixel_variants_unit
    import ispv_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte0,
    input  logic [7:0]            in_byte1,
    input  logic [7:0]            in_byte2,
    input  logic [7:0]            in_byte3,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [31:0]           normal_pixel,
    output logic [31:0]           clicked_pixel,
    output logic [31:0]           disabled_pixel,
    output logic [31:0]           disabled_clicked_pixel
);

    logic [1:0] pixel_format_reg;
    logic [2:0] variant_mask_reg;

    logic big;
    logic has_alpha;
    logic want_dis;
    logic want_clk;

    assign big = pixel_format_reg[FMT_BIG_BIT];
    assign has_alpha = pixel_format_reg[FMT_ALPHA_BIT];
    assign want_dis = variant_mask_reg[MASK_DIS_BIT];
    assign want_clk = variant_mask_reg[MASK_ACT_BIT] | variant_mask_reg[MASK_PART_BIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_format_reg <= FMT_RESET;
            variant_mask_reg <= MASK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[1:0];
                REG_VARIANT_MASK: variant_mask_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage valids and advance
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg;
    logic adv1, adv2, adv3, adv4, adv5;

    assign adv5 = !s5_valid_reg || out_ready;
    assign adv4 = !s4_valid_reg || adv5;
    assign adv3 = !s3_valid_reg || adv4;
    assign adv2 = !s2_valid_reg || adv3;
    assign adv1 = !s1_valid_reg || adv2;
    assign in_ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            s5_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1) s1_valid_reg <= in_valid;
            if (adv2) s2_valid_reg <= s1_valid_reg;
            if (adv3) s3_valid_reg <= s2_valid_reg;
            if (adv4) s4_valid_reg <= s3_valid_reg;
            if (adv5) s5_valid_reg <= s4_valid_reg;
        end
    end

    // stage 1: byte order to logical channels
    pix4_t n1_reg, n1_next;

    always_comb
    begin
        if (big)
        begin
            n1_next[0] = in_byte3;
            n1_next[1] = in_byte2;
            n1_next[2] = in_byte1;
            n1_next[3] = has_alpha ? in_byte0 : OPAQUE_ALPHA;
        end
        else
        begin
            n1_next[0] = in_byte0;
            n1_next[1] = in_byte1;
            n1_next[2] = in_byte2;
            n1_next[3] = has_alpha ? in_byte3 : OPAQUE_ALPHA;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1) n1_reg <= n1_next;
    end

    // stage 2: clicked, opaque disabled, alpha cut and grey sum
    pix4_t n2_reg, c2_reg, od2_reg, odc2_reg;
    pix4_t c2_next, od2_next, odc2_next;
    chan_t da2_reg, da2_next;
    logic [14:0] gsum2_reg, gsum2_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            c2_next[k] = div5_f({1'b0, n1_reg[k], 2'b00});
            od2_next[k] = div5_f({2'b00, n1_reg[k], 1'b0} + DIS_OFFSET);
            odc2_next[k] = div5_f({2'b00, n1_reg[k], 1'b0} + DIS_CLK_OFFSET);
        end
        c2_next[3] = n1_reg[3];
        od2_next[3] = OPAQUE_ALPHA;
        odc2_next[3] = OPAQUE_ALPHA;
        da2_next = div10_f(12'(n1_reg[3]) * 12'd3);
        gsum2_next = 15'(n1_reg[0]) * 15'd10 + 15'(n1_reg[1]) * 15'd60
                   + 15'(n1_reg[2]) * 15'd30;
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            n2_reg <= n1_reg;
            c2_reg <= c2_next;
            od2_reg <= od2_next;
            odc2_reg <= odc2_next;
            da2_reg <= da2_next;
            gsum2_reg <= gsum2_next;
        end
    end

    // stage 3: grey
    pix4_t n3_reg, c3_reg, od3_reg, odc3_reg;
    chan_t da3_reg, grey3_reg;

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            n3_reg <= n2_reg;
            c3_reg <= c2_reg;
            od3_reg <= od2_reg;
            odc3_reg <= odc2_reg;
            da3_reg <= da2_reg;
            grey3_reg <= div100_f(gsum2_reg);
        end
    end

    // stage 4: desaturated colors
    pix4_t n4_reg, c4_reg, od4_reg, odc4_reg, d4_reg, d4_next;
    chan_t da4_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d4_next[k] = div10_f(12'(grey3_reg) * 12'd7 + 12'(n3_reg[k]) * 12'd3);
        end
        d4_next[3] = da3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv4)
        begin
            n4_reg <= n3_reg;
            c4_reg <= c3_reg;
            od4_reg <= od3_reg;
            odc4_reg <= odc3_reg;
            da4_reg <= da3_reg;
            d4_reg <= d4_next;
        end
    end

    // stage 5: darkened disabled, selection, packing and masking
    pix4_t dc5, dis5, disc5;
    logic [31:0] normal_reg, clicked_reg, disabled_reg, dis_clk_reg;
    logic [31:0] normal_next, clicked_next, disabled_next, dis_clk_next;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            dc5[k] = div5_f({1'b0, d4_reg[k], 2'b00});
        end
        dc5[3] = da4_reg;
        dis5 = has_alpha ? d4_reg : od4_reg;
        disc5 = has_alpha ? dc5 : odc4_reg;
        normal_next = pack_f(big, n4_reg);
        clicked_next = want_clk ? pack_f(big, c4_reg) : 32'd0;
        disabled_next = want_dis ? pack_f(big, dis5) : 32'd0;
        dis_clk_next = (want_dis && want_clk) ? pack_f(big, disc5) : 32'd0;
    end

    always_ff @(posedge clk)
    begin
        if (adv5)
        begin
            normal_reg <= normal_next;
            clicked_reg <= clicked_next;
            disabled_reg <= disabled_next;
            dis_clk_reg <= dis_clk_next;
        end
    end

    assign out_valid = s5_valid_reg;
    assign normal_pixel = normal_reg;
    assign clicked_pixel = clicked_reg;
    assign disabled_pixel = disabled_reg;
    assign disabled_clicked_pixel = dis_clk_reg;

`ifndef SYNTHESIS
    // input side only blocks when every stage is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (s1_valid_reg && s2_valid_reg && s3_valid_reg
                       && s4_valid_reg && s5_valid_reg && !out_ready))
        else $error("input stalled with a free pipeline slot");

    // disabled variants are zero when not enabled
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !want_dis) |-> (disabled_pixel == 32'd0
                                      && disabled_clicked_pixel == 32'd0))
        else $error("disabled variant present while not enabled");

    // opaque formats always carry full alpha in the normal variant
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !has_alpha) |->
            ((big ? normal_pixel[7:0] : normal_pixel[31:24]) == OPAQUE_ALPHA))
        else $error("opaque normal variant lost its alpha");
`endif

endmodule
